[design/mom_pkg.sv]
// Shared types and constants for the market order matcher.
// Depends on nothing; the matcher unit refers to it by scoped names.
package mom_pkg;

  localparam int NUM_STOCKS_DEF  = 64;
  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int STOCK_W = 6;
  localparam int QTY_W   = 24;
  localparam int OID_W   = 32;
  localparam int TID_W   = 16;

  localparam logic STATUS_FILLED = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_WALK,
    S_SELF
  } mom_state_t;

endpackage

[design/market_order_matcher_unit.sv]
// Market order matcher: one FIFO order book per stock, kept in two memories.
// A taken order is first looked up in its book: a full book on its own side rejects it, and
// a book on the other side is walked entry by entry, with busy held until the walk ends;
// orders that rest, are rejected or find nothing return to idle after the lookup.
// Reset clears the book memory, one book word per stock in turn, with busy high.
// Results appear for one cycle on valid; the receiver cannot stall them.
module market_order_matcher_unit #(
  parameter int NUM_STOCKS  = mom_pkg::NUM_STOCKS_DEF,
  parameter int QUEUE_DEPTH = mom_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [mom_pkg::STOCK_W-1:0] stock_index,
  input  logic                       side,
  input  logic [mom_pkg::QTY_W-1:0]  quantity,
  input  logic [mom_pkg::OID_W-1:0]  order_id,
  input  logic [mom_pkg::TID_W-1:0]  trader_id,
  output logic                       valid,
  output logic [mom_pkg::OID_W-1:0]  filled_order,
  output logic [mom_pkg::TID_W-1:0]  notify_trader,
  output logic                       status,
  output logic                       last
);

  // Address and field widths follow from the two parameters.
  localparam int SW    = (NUM_STOCKS > 1) ? $clog2(NUM_STOCKS) : 1;
  localparam int SLOTS = NUM_STOCKS * QUEUE_DEPTH;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int QW    = $clog2(QUEUE_DEPTH);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int BW    = 2 + QW + CW;
  localparam int EW    = mom_pkg::OID_W + mom_pkg::TID_W + mom_pkg::QTY_W;

  localparam logic [AW-1:0] QD_A   = AW'(QUEUE_DEPTH);
  localparam logic [QW-1:0] QD_MAX = QW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] QD_CNT = CW'(QUEUE_DEPTH);
  localparam logic [SW-1:0] CLR_END = SW'(NUM_STOCKS - 1);

  // Control state.
  mom_pkg::mom_state_t st, st_next;
  logic [SW-1:0] clr_cnt;

  // The order in flight. The quantity shrinks as resting orders are consumed.
  logic [SW-1:0]               r_stock;
  logic                        r_side;
  logic [mom_pkg::QTY_W-1:0]   r_qty, r_qty_next;
  logic [mom_pkg::OID_W-1:0]   r_oid;
  logic [mom_pkg::TID_W-1:0]   r_tid;

  // Working copy of the book's head and count during a walk.
  logic [QW-1:0] b_head, b_head_next;
  logic [CW-1:0] b_count, b_count_next;

  // Result register.
  logic                      valid_next;
  logic [mom_pkg::OID_W-1:0] filled_order_next;
  logic [mom_pkg::TID_W-1:0] notify_trader_next;
  logic                      status_next;
  logic                      last_next;

  // Memory ports.
  logic          bk_we;
  logic [SW-1:0] bk_waddr, bk_raddr;
  logic [BW-1:0] bk_wdata, bk_rdata;
  logic          en_we;
  logic [AW-1:0] en_waddr, en_raddr;
  logic [EW-1:0] en_wdata, en_rdata;

  // Fields of the book word as read back.
  logic          rd_seen, rd_open;
  logic [QW-1:0] rd_head;
  logic [CW-1:0] rd_count;

  // Fields of the resting entry as read back.
  logic [mom_pkg::OID_W-1:0] e_id;
  logic [mom_pkg::TID_W-1:0] e_tr;
  logic [mom_pkg::QTY_W-1:0] e_sz;

  logic          accept;
  logic          in_range;
  logic [QW-1:0] nh;
  logic [CW-1:0] nc;

  assign {rd_seen, rd_open, rd_head, rd_count} = bk_rdata;
  assign {e_id, e_tr, e_sz} = en_rdata;

  assign busy     = (st != mom_pkg::S_IDLE);
  assign in_range = (32'(stock_index) < NUM_STOCKS);
  assign accept   = start && !busy;

  // The queue position after the last resting entry, modulo the depth.
  function automatic logic [QW-1:0] tail_pos(input logic [QW-1:0] h, input logic [CW-1:0] c);
    logic [CW:0] sum;
    sum = (CW + 1)'(h) + (CW + 1)'(c);
    if (sum >= (CW + 1)'(QUEUE_DEPTH)) begin
      sum = sum - (CW + 1)'(QUEUE_DEPTH);
    end
    return QW'(sum);
  endfunction

  // Memory address of a queue position within a stock's region.
  function automatic logic [AW-1:0] slot(input logic [SW-1:0] s, input logic [QW-1:0] p);
    return AW'(s) * QD_A + AW'(p);
  endfunction

  // Head advanced by one pop, and the count after it.
  assign nh = (b_head == QD_MAX) ? '0 : b_head + 1'b1;
  assign nc = b_count - 1'b1;

  mom_ram #(.WIDTH(BW), .DEPTH(NUM_STOCKS)) u_book (
    .clk   (clk),
    .we    (bk_we),
    .waddr (bk_waddr),
    .wdata (bk_wdata),
    .raddr (bk_raddr),
    .rdata (bk_rdata)
  );

  mom_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_slots (
    .clk   (clk),
    .we    (en_we),
    .waddr (en_waddr),
    .wdata (en_wdata),
    .raddr (en_raddr),
    .rdata (en_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= mom_pkg::S_CLEAR;
      clr_cnt <= '0;
      valid   <= 1'b0;
    end else begin
      st    <= st_next;
      valid <= valid_next;
      if (st == mom_pkg::S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      r_stock <= SW'(stock_index);
      r_side  <= side;
      r_oid   <= order_id;
      r_tid   <= trader_id;
    end
    r_qty         <= accept ? quantity : r_qty_next;
    b_head        <= b_head_next;
    b_count       <= b_count_next;
    filled_order  <= filled_order_next;
    notify_trader <= notify_trader_next;
    status        <= status_next;
    last          <= last_next;
  end

  // Sequencer: look up the book, then walk resting entries one per cycle.
  // Every write of the book word outside the reset clear happens in the cycle that returns to idle,
  // so the next transaction always reads the updated word.
  always_comb begin
    st_next            = st;
    r_qty_next         = r_qty;
    b_head_next        = b_head;
    b_count_next       = b_count;
    valid_next         = 1'b0;
    filled_order_next  = r_oid;
    notify_trader_next = r_tid;
    status_next        = mom_pkg::STATUS_FILLED;
    last_next          = 1'b0;
    bk_we              = 1'b0;
    bk_waddr           = r_stock;
    bk_wdata           = '0;
    bk_raddr           = SW'(stock_index);
    en_we              = 1'b0;
    en_waddr           = slot(r_stock, b_head);
    en_wdata           = {r_oid, r_tid, r_qty};
    en_raddr           = slot(r_stock, b_head);

    case (st)
      mom_pkg::S_CLEAR: begin
        bk_we    = 1'b1;
        bk_waddr = clr_cnt;
        if (clr_cnt == CLR_END) begin
          st_next = mom_pkg::S_IDLE;
        end
      end

      mom_pkg::S_IDLE: begin
        if (accept && in_range) begin
          st_next = mom_pkg::S_LOOKUP;
        end
      end

      mom_pkg::S_LOOKUP: begin
        st_next      = mom_pkg::S_IDLE;
        b_head_next  = rd_head;
        b_count_next = rd_count;
        if (!rd_seen) begin
          // First order of a stock always rests and sets the open side.
          en_we    = 1'b1;
          en_waddr = slot(r_stock, tail_pos(rd_head, rd_count));
          bk_we    = 1'b1;
          bk_wdata = {1'b1, r_side, rd_head, rd_count + 1'b1};
        end else if (r_side == rd_open) begin
          if (rd_count == QD_CNT) begin
            valid_next  = 1'b1;
            status_next = mom_pkg::STATUS_REJECT;
            last_next   = 1'b1;
          end else begin
            en_we    = 1'b1;
            en_waddr = slot(r_stock, tail_pos(rd_head, rd_count));
            bk_we    = 1'b1;
            bk_wdata = {1'b1, rd_open, rd_head, rd_count + 1'b1};
          end
        end else if (rd_count == '0) begin
          // Empty book on the other side: a nonzero order rests and flips it.
          if (r_qty != '0) begin
            en_we    = 1'b1;
            en_waddr = slot(r_stock, rd_head);
            bk_we    = 1'b1;
            bk_wdata = {1'b1, r_side, rd_head, CW'(1)};
          end
        end else begin
          en_raddr = slot(r_stock, rd_head);
          st_next  = mom_pkg::S_WALK;
        end
      end

      mom_pkg::S_WALK: begin
        valid_next = 1'b1;
        if (e_sz > r_qty) begin
          // The head is larger: shrink it in place and fill the incoming order.
          en_we     = 1'b1;
          en_waddr  = slot(r_stock, b_head);
          en_wdata  = {e_id, e_tr, e_sz - r_qty};
          last_next = 1'b1;
          bk_we     = 1'b1;
          bk_wdata  = {1'b1, ~r_side, b_head, b_count};
          st_next   = mom_pkg::S_IDLE;
        end else begin
          filled_order_next  = e_id;
          notify_trader_next = e_tr;
          b_head_next        = nh;
          b_count_next       = nc;
          if (e_sz == r_qty) begin
            st_next = mom_pkg::S_SELF;
          end else begin
            r_qty_next = r_qty - e_sz;
            if (nc == '0) begin
              // Book ran dry: the remainder rests and the open side flips.
              last_next = 1'b1;
              en_we     = 1'b1;
              en_waddr  = slot(r_stock, nh);
              en_wdata  = {r_oid, r_tid, r_qty - e_sz};
              bk_we     = 1'b1;
              bk_wdata  = {1'b1, r_side, nh, CW'(1)};
              st_next   = mom_pkg::S_IDLE;
            end else begin
              en_raddr = slot(r_stock, nh);
            end
          end
        end
      end

      mom_pkg::S_SELF: begin
        valid_next = 1'b1;
        last_next  = 1'b1;
        bk_we      = 1'b1;
        bk_wdata   = {1'b1, ~r_side, b_head, b_count};
        st_next    = mom_pkg::S_IDLE;
      end

      default: begin
        st_next = mom_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[design/mom_ram.sv]
// Single-port-write, single-port-read synchronous memory with registered read data.
// Depends on nothing but its parameters.
module mom_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
